// ===== hdl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Item types, field widths, command codes and parameter defaults.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int MAX_PAGES_DEF     = 4096;
    localparam int BITS_PER_WORD_DEF = 8;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int LIMIT_W = 13;
    localparam int FREE_W  = 13;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_FREE     = 2'd0,
        CMD_ALLOC_AT = 2'd1,
        CMD_FIND     = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd                 command;
        logic [INDEX_W-1:0]   page_index;
        logic [COUNT_W-1:0]   page_count;
    } t_in_item;

    typedef struct packed {
        logic                 status;
        logic [INDEX_W-1:0]   found_page;
        logic [FREE_W-1:0]    free_pages;
    } t_out_item;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ===== hdl/page_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator
// First-fit page-frame allocator over a one-bit-per-page map (1 = free).
//
// Input channel (i_in_valid / o_in_stall) takes one command item: free a run,
// allocate a run at a page, or find and allocate a run from page 0. Output
// channel (o_out_valid / i_out_stall) gives one result item per command:
// status, first page found by a find and the free page count afterwards.
// i_cfg_we writes the page limit; write it only while the block is idle.
//
// The map lives in a word-wide memory walked by one sequencer, one page per
// cycle except while a map word is read, which takes a load and a fetch state.
// The result is registered once the walk ends and the output register is free,
// and the block then takes the next item. Free walks the run; allocate-at walks
// it to check it and, if it is all free, again to claim it; find walks up to
// the first fitting run and then claims it. A failed find walks every page
// below the limit. The block takes one item at a time; o_in_stall is high
// while an item is at work. The result sits in an output register, so a
// stalled receiver does not hold back the next accept, only the next result.
// After reset a clearing pass over all MAP_WORDS map words (512 at default
// settings) marks every page used; o_in_stall stays high throughout.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_unit #(
    parameter int MAX_PAGES     = pba_pkg::MAX_PAGES_DEF,
    parameter int BITS_PER_WORD = pba_pkg::BITS_PER_WORD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pba_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    input  pba_pkg::t_in_item             i_in_item,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pba_pkg::t_out_item            o_out_item
);

    localparam int MAP_WORDS = (MAX_PAGES + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [pba_pkg::LIMIT_W-1:0] r_page_limit;
    pba_pkg::t_mem_ctl           mem_ctl;
    logic [WAW-1:0]              rd_addr;
    logic [WAW-1:0]              wr_addr;
    logic [BITS_PER_WORD-1:0]    wr_data;
    logic [BITS_PER_WORD-1:0]    rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_limit <= pba_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_page_limit <= i_cfg_wdata;
        end
    end

    pba_ctrl #(
        .MAX_PAGES     (MAX_PAGES),
        .BITS_PER_WORD (BITS_PER_WORD),
        .MAP_WORDS     (MAP_WORDS),
        .WAW           (WAW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_page_limit (r_page_limit),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item),
        .o_mem_ctl    (mem_ctl),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_rd_data    (rd_data)
    );

    pba_map_mem #(
        .WORDS  (MAP_WORDS),
        .WIDTH  (BITS_PER_WORD),
        .ADDR_W (WAW)
    ) u_map (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

// ===== hdl/pba_map_mem.sv =====
// ----------------------------------------------------------------------------
// Page map memory
// One word of page bits per entry; one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module pba_map_mem #(
    parameter int WORDS  = 512,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 9
) (
    input  logic                i_clk,
    input  pba_pkg::t_mem_ctl   i_ctl,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]    i_wr_data,
    output logic [WIDTH-1:0]    o_rd_data
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/pba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator sequencer
// Walks the page map through a word buffer, one page a cycle between word
// loads, in set, check, search and claim passes; holds the result register.
// ----------------------------------------------------------------------------
module pba_ctrl #(
    parameter int MAX_PAGES     = pba_pkg::MAX_PAGES_DEF,
    parameter int BITS_PER_WORD = pba_pkg::BITS_PER_WORD_DEF,
    parameter int MAP_WORDS     = (MAX_PAGES + BITS_PER_WORD - 1) / BITS_PER_WORD,
    parameter int WAW           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pba_pkg::LIMIT_W-1:0]   i_page_limit,
    input  logic                          i_in_valid,
    input  pba_pkg::t_in_item             i_in_item,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pba_pkg::t_out_item            o_out_item,
    output pba_pkg::t_mem_ctl             o_mem_ctl,
    output logic [WAW-1:0]                o_rd_addr,
    output logic [WAW-1:0]                o_wr_addr,
    output logic [BITS_PER_WORD-1:0]      o_wr_data,
    input  logic [BITS_PER_WORD-1:0]      i_rd_data
);

    localparam int OW = $clog2(BITS_PER_WORD);
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int AW = ((CW > pba_pkg::LIMIT_W) ? CW : pba_pkg::LIMIT_W) + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_FETCH, S_STEP, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        P_SET, P_CHECK, P_SEARCH, P_CLAIM
    } t_pass;

    t_state                    r_state;
    t_pass                     r_pass;
    logic [AW-1:0]             r_ptr;
    logic [AW-1:0]             r_end;
    logic [AW-1:0]             r_cnt;
    logic [AW-1:0]             r_run;
    logic [AW-1:0]             r_found;
    logic [BITS_PER_WORD-1:0]  r_word;
    logic [CW-1:0]             r_free;
    logic                      r_status;
    logic                      r_out_valid;
    pba_pkg::t_out_item        r_out;

    logic [AW-1:0]             lim_ext;
    logic [AW-1:0]             eff_lim;
    logic [AW-1:0]             in_idx;
    logic [AW-1:0]             in_cnt;
    logic [AW-1:0]             in_sum;
    logic [AW-1:0]             ptr_inc;
    logic [AW-1:0]             run_inc;
    logic [AW-1:0]             free_ext;
    logic [OW-1:0]             off;
    logic                      cur_bit;
    logic                      last;
    logic                      boundary;
    logic                      modifying;
    logic                      in_acc;
    logic                      out_free;
    logic [BITS_PER_WORD-1:0]  w_mod;

    always_comb begin
        lim_ext  = AW'(i_page_limit);
        eff_lim  = (lim_ext > AW'(MAX_PAGES)) ? AW'(MAX_PAGES) : lim_ext;
        in_idx   = AW'(i_in_item.page_index);
        in_cnt   = AW'(i_in_item.page_count);
        in_sum   = in_idx + in_cnt;
        ptr_inc  = r_ptr + AW'(1);
        run_inc  = r_run + AW'(1);
        free_ext = AW'(r_free);
        off      = r_ptr[OW-1:0];
        cur_bit  = r_word[off];
        last     = (ptr_inc == r_end);
        boundary = (ptr_inc[OW-1:0] == '0);
        modifying = (r_pass == P_SET) || (r_pass == P_CLAIM);
        w_mod      = r_word;
        w_mod[off] = (r_pass == P_SET);
    end

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_mem_ctl.rd_en = (r_state == S_LOAD);
        o_mem_ctl.wr_en = (r_state == S_CLEAR) ||
                          ((r_state == S_STEP) && modifying && (last || boundary));
        o_rd_addr = WAW'(r_ptr >> OW);
        o_wr_addr = (r_state == S_CLEAR) ? WAW'(r_ptr) : WAW'(r_ptr >> OW);
        o_wr_data = (r_state == S_CLEAR) ? '0 : w_mod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    // sweep the map to all-used, one word a cycle
                    if (r_ptr == AW'(MAP_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= ptr_inc;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_cnt    <= in_cnt;
                        r_run    <= '0;
                        r_found  <= '0;
                        priority if (i_in_item.command == pba_pkg::CMD_FREE ||
                                     i_in_item.command == pba_pkg::CMD_ALLOC_AT) begin
                            r_ptr  <= in_idx;
                            r_end  <= in_sum;
                            r_pass <= (i_in_item.command == pba_pkg::CMD_FREE) ?
                                      P_SET : P_CHECK;
                            if ((in_sum <= eff_lim) && (in_cnt != '0)) begin
                                r_status <= pba_pkg::STATUS_FAIL;
                                r_state  <= S_LOAD;
                            end else begin
                                r_status <= (in_sum <= eff_lim) ?
                                            pba_pkg::STATUS_OK : pba_pkg::STATUS_FAIL;
                                r_state  <= S_DONE;
                            end
                        end else if (i_in_item.command == pba_pkg::CMD_FIND) begin
                            r_ptr  <= '0;
                            r_end  <= eff_lim;
                            r_pass <= P_SEARCH;
                            if ((eff_lim != '0) && (in_cnt != '0)) begin
                                r_status <= pba_pkg::STATUS_FAIL;
                                r_state  <= S_LOAD;
                            end else begin
                                r_status <= (eff_lim != '0) ?
                                            pba_pkg::STATUS_OK : pba_pkg::STATUS_FAIL;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            // unused command code: fail, change nothing
                            r_status <= pba_pkg::STATUS_FAIL;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_word  <= i_rd_data;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    unique case (r_pass)
                        P_SET, P_CLAIM: begin
                            r_word <= w_mod;
                            if (r_pass == P_CLAIM) begin
                                r_free <= r_free - CW'(1);
                            end else if (!cur_bit) begin
                                r_free <= r_free + CW'(1);
                            end
                            if (last) begin
                                r_status <= pba_pkg::STATUS_OK;
                                r_state  <= S_DONE;
                            end else begin
                                r_ptr <= ptr_inc;
                                if (boundary) begin
                                    r_state <= S_LOAD;
                                end
                            end
                        end
                        P_CHECK: begin
                            if (!cur_bit) begin
                                r_state <= S_DONE;
                            end else if (last) begin
                                // whole run free: go back and claim it
                                r_ptr   <= r_end - r_cnt;
                                r_pass  <= P_CLAIM;
                                r_state <= S_LOAD;
                            end else begin
                                r_ptr <= ptr_inc;
                                if (boundary) begin
                                    r_state <= S_LOAD;
                                end
                            end
                        end
                        P_SEARCH: begin
                            if (cur_bit && (run_inc == r_cnt)) begin
                                r_found <= ptr_inc - r_cnt;
                                r_ptr   <= ptr_inc - r_cnt;
                                r_end   <= ptr_inc;
                                r_pass  <= P_CLAIM;
                                r_state <= S_LOAD;
                            end else if (last) begin
                                r_state <= S_DONE;
                            end else begin
                                r_run <= cur_bit ? run_inc : '0;
                                r_ptr <= ptr_inc;
                                if (boundary) begin
                                    r_state <= S_LOAD;
                                end
                            end
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_DONE: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        r_out.status     <= r_status;
                        r_out.found_page <= (r_status == pba_pkg::STATUS_OK) ?
                                            r_found[pba_pkg::INDEX_W-1:0] : '0;
                        r_out.free_pages <= free_ext[pba_pkg::FREE_W-1:0];
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hdl/pba_checker.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module pba_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pba_pkg::t_in_item   i_in_item,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  pba_pkg::t_out_item  o_out_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // reset starts the clearing pass, so no item is taken next cycle
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // one item at a time: an accept closes the input for the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while busy");

    // a failed command reports no page
    a_fail_no_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == pba_pkg::STATUS_FAIL)
            |-> (o_out_item.found_page == '0))
        else $error("failed command reports a page");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
